### rtl/wdp_pkg.sv
// ----------------------------------------------------------------------------
// wdp_pkg
// Shared types and constants for the waypoint distance PID controller.
// ----------------------------------------------------------------------------
package wdp_pkg;

  localparam int NUM_TARGETS_DEF = 3;
  localparam int CFG_IDX_W       = 4;

  localparam int ERR_W   = 33;
  localparam int SUM_W   = 48;
  localparam int DERIV_W = 34;
  localparam int TERM_W  = 63;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 4'd0,
    REG_INTEGRAL_GAIN = 4'd1,
    REG_DERIV_GAIN    = 4'd2,
    REG_SPEED_LIMIT   = 4'd3,
    REG_BOOST_DIST    = 4'd4,
    REG_TARGET_FIRST  = 4'd5,
    REG_TARGET_SECOND = 4'd6,
    REG_TARGET_THIRD  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integral_gain_per_tick;
    logic signed [31:0] deriv_gain_per_tick;
    logic signed [31:0] speed_limit;
    logic signed [31:0] boost_distance;
    logic signed [31:0] target_first;
    logic signed [31:0] target_second;
    logic signed [31:0] target_third;
  } wdp_cfg_t;

  localparam logic signed [31:0] RST_PROP_GAIN     = 32'sd65536;
  localparam logic signed [31:0] RST_INTEGRAL_GAIN = 32'sd655;
  localparam logic signed [31:0] RST_DERIV_GAIN    = 32'sd32768;
  localparam logic signed [31:0] RST_SPEED_LIMIT   = 32'sd65536;
  localparam logic signed [31:0] RST_BOOST_DIST    = 32'sd32768;
  localparam logic signed [31:0] RST_TARGET_FIRST  = 32'sd65536;
  localparam logic signed [31:0] RST_TARGET_SECOND = 32'sd131072;
  localparam logic signed [31:0] RST_TARGET_THIRD  = 32'sd196608;

  // per-transaction control bits that ride along the pipeline
  typedef struct packed {
    logic       done;
    logic       boost;
    logic       arrived;
    logic       finished;
    logic [1:0] idx;
  } wdp_flags_t;

  localparam logic [1:0] IDX_DONE = 2'd3;

  localparam logic signed [ERR_W-1:0] ARRIVE_TOL = 33'sd655;
  localparam logic signed [65:0] TERM_LIM = 66'sh0_2000_0000_0000_0000;
  localparam logic signed [64:0] CMD_MIN  = -65'sd2147483648;

endpackage

### rtl/waypoint_distance_pid.sv
// ----------------------------------------------------------------------------
// waypoint_distance_pid
// PID speed controller over a list of waypoint distances, output capped at
// the speed limit, with a full-speed boost near the start.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    measured_distance
//  output    out        out_valid / out_stall  speed_command, target_number,
//                                              boost_used, arrived, finished
//  config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one transaction per cycle while out_stall stays low; a result passes through
//  the input reg, state update, partial products, terms and result registers
//  the integral/derivative state closes its loop in the state update stage only
//  rst clears the pipeline valids, the PID state and loads register defaults
//  out_stall backs up stage by stage; empty stages still take new transactions
// ----------------------------------------------------------------------------
module waypoint_distance_pid import wdp_pkg::*; #(
  parameter int NUM_TARGETS = NUM_TARGETS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   measured_distance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   speed_command,
  output logic [1:0]           target_number,
  output logic                 boost_used,
  output logic                 arrived,
  output logic                 finished,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  wdp_cfg_t                  cfg;

  logic                      f_valid;
  logic                      f_ready;
  logic signed [ERR_W-1:0]   f_err;
  logic signed [SUM_W-1:0]   f_sum;
  logic signed [DERIV_W-1:0] f_deriv;
  wdp_flags_t                f_flags;

  logic                      t_valid;
  logic                      t_ready;
  logic signed [TERM_W-1:0]  t_p;
  logic signed [TERM_W-1:0]  t_i;
  logic signed [TERM_W-1:0]  t_d;
  wdp_flags_t                t_flags;

  wdp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wdp_front #(
    .NUM_TARGETS (NUM_TARGETS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .measured_distance (measured_distance),
    .stage_valid       (f_valid),
    .stage_ready       (f_ready),
    .err_q             (f_err),
    .sum_q             (f_sum),
    .deriv_q           (f_deriv),
    .flags_q           (f_flags)
  );

  wdp_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .err        (f_err),
    .sum        (f_sum),
    .deriv      (f_deriv),
    .flags      (f_flags),
    .term_valid (t_valid),
    .term_ready (t_ready),
    .term_p     (t_p),
    .term_i     (t_i),
    .term_d     (t_d),
    .term_flags (t_flags)
  );

  wdp_out u_out (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (t_valid),
    .in_ready      (t_ready),
    .term_p        (t_p),
    .term_i        (t_i),
    .term_d        (t_d),
    .flags         (t_flags),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .speed_command (speed_command),
    .target_number (target_number),
    .boost_used    (boost_used),
    .arrived       (arrived),
    .finished      (finished)
  );

`ifndef SYNTHESIS
  // finished only on the arrival at the last waypoint or after it
  a_finished_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> (target_number == IDX_DONE) || arrived)
    else $error("finished without arrival or done index");

  // once done, the command is a plain stop
  a_done_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && (target_number == IDX_DONE) |->
      finished && !arrived && !boost_used && (speed_command == 32'sd0))
    else $error("done transaction carries a nonzero command or stray flags");

  // boost is only ever taken on the first waypoint
  a_boost_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && boost_used |-> (target_number == 2'd0))
    else $error("boost used beyond the first waypoint");
`endif

endmodule

### rtl/wdp_cfg.sv
// ----------------------------------------------------------------------------
// wdp_cfg
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module wdp_cfg import wdp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output wdp_cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain              <= RST_PROP_GAIN;
      cfg.integral_gain_per_tick <= RST_INTEGRAL_GAIN;
      cfg.deriv_gain_per_tick    <= RST_DERIV_GAIN;
      cfg.speed_limit            <= RST_SPEED_LIMIT;
      cfg.boost_distance         <= RST_BOOST_DIST;
      cfg.target_first           <= RST_TARGET_FIRST;
      cfg.target_second          <= RST_TARGET_SECOND;
      cfg.target_third           <= RST_TARGET_THIRD;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:     cfg.prop_gain              <= cfg_data;
        REG_INTEGRAL_GAIN: cfg.integral_gain_per_tick <= cfg_data;
        REG_DERIV_GAIN:    cfg.deriv_gain_per_tick    <= cfg_data;
        REG_SPEED_LIMIT:   cfg.speed_limit            <= cfg_data;
        REG_BOOST_DIST:    cfg.boost_distance         <= cfg_data;
        REG_TARGET_FIRST:  cfg.target_first           <= cfg_data;
        REG_TARGET_SECOND: cfg.target_second          <= cfg_data;
        REG_TARGET_THIRD:  cfg.target_third           <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/wdp_front.sv
// ----------------------------------------------------------------------------
// wdp_front
// Input register, error/integral/derivative update and waypoint tracking.
// ----------------------------------------------------------------------------
module wdp_front import wdp_pkg::*; #(
  parameter int NUM_TARGETS = NUM_TARGETS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  wdp_cfg_t                  cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [31:0]        measured_distance,
  output logic                      stage_valid,
  input  logic                      stage_ready,
  output logic signed [ERR_W-1:0]   err_q,
  output logic signed [SUM_W-1:0]   sum_q,
  output logic signed [DERIV_W-1:0] deriv_q,
  output wdp_flags_t                flags_q
);

  localparam logic [2:0] NT = 3'(NUM_TARGETS);

  logic                      dist_valid;
  logic signed [31:0]        distance;
  logic                      ready0;
  logic                      ready1;

  logic signed [SUM_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   last_error;
  logic [1:0]                target_index;

  logic signed [31:0]        target;
  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W:0]     sum_raw;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [DERIV_W-1:0] deriv;
  logic                      done;
  logic                      boost;
  logic                      near;

  assign ready1   = !stage_valid || stage_ready;
  assign ready0   = !dist_valid || ready1;
  assign in_stall = !ready0;

  always_comb begin
    case (target_index)
      2'd0:    target = cfg.target_first;
      2'd1:    target = cfg.target_second;
      default: target = cfg.target_third;
    endcase
  end

  assign done    = ({1'b0, target_index} >= NT);
  assign err     = ERR_W'(target) - ERR_W'(distance);
  assign boost   = (target_index == 2'd0) && (distance < cfg.boost_distance);
  assign sum_raw = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err);
  assign deriv   = DERIV_W'(err) - DERIV_W'(last_error);
  assign near    = (err <= ARRIVE_TOL) && (err >= -ARRIVE_TOL);

  // saturate the running sum to 48 bits
  always_comb begin
    if (sum_raw[SUM_W] != sum_raw[SUM_W-1]) begin
      sum_sat = {sum_raw[SUM_W], {(SUM_W-1){!sum_raw[SUM_W]}}};
    end else begin
      sum_sat = sum_raw[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (ready0) begin
      dist_valid <= in_valid;
    end
    if (in_valid && ready0) begin
      distance <= measured_distance;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      error_sum    <= '0;
      last_error   <= '0;
      target_index <= '0;
    end else begin
      if (ready1) begin
        stage_valid <= dist_valid;
      end
      if (dist_valid && ready1 && !done) begin
        if (near) begin
          error_sum    <= '0;
          last_error   <= '0;
          target_index <= target_index + 2'd1;
        end else if (!boost) begin
          error_sum  <= sum_sat;
          last_error <= err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dist_valid && ready1) begin
      err_q            <= err;
      sum_q            <= sum_sat;
      deriv_q          <= deriv;
      flags_q.done     <= done;
      flags_q.boost    <= boost && !done;
      flags_q.arrived  <= near && !done;
      flags_q.finished <= done || (near && (({1'b0, target_index} + 3'd1) >= NT));
      flags_q.idx      <= done ? IDX_DONE : target_index;
    end
  end

endmodule

### rtl/wdp_mult.sv
// ----------------------------------------------------------------------------
// wdp_mult
// Gain products split into high and low partial products, then recombined
// with a floor shift by 16 and clamped to +-2^61.
// ----------------------------------------------------------------------------
module wdp_mult import wdp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  wdp_cfg_t                  cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ERR_W-1:0]   err,
  input  logic signed [SUM_W-1:0]   sum,
  input  logic signed [DERIV_W-1:0] deriv,
  input  wdp_flags_t                flags,
  output logic                      term_valid,
  input  logic                      term_ready,
  output logic signed [TERM_W-1:0]  term_p,
  output logic signed [TERM_W-1:0]  term_i,
  output logic signed [TERM_W-1:0]  term_d,
  output wdp_flags_t                term_flags
);

  logic              pp_valid;
  logic              pp_ready;
  wdp_flags_t        pp_flags;

  logic signed [16:0] err_hi;
  logic signed [16:0] err_lo;
  logic signed [31:0] sum_hi;
  logic signed [16:0] sum_lo;
  logic signed [17:0] deriv_hi;
  logic signed [16:0] deriv_lo;

  logic signed [48:0] pp_p_hi;
  logic signed [48:0] pp_p_lo;
  logic signed [63:0] pp_i_hi;
  logic signed [48:0] pp_i_lo;
  logic signed [49:0] pp_d_hi;
  logic signed [48:0] pp_d_lo;

  logic signed [65:0] full_p;
  logic signed [65:0] full_i;
  logic signed [65:0] full_d;

  // low halves are unsigned 16-bit digits
  assign err_hi   = err[ERR_W-1:16];
  assign err_lo   = {1'b0, err[15:0]};
  assign sum_hi   = sum[SUM_W-1:16];
  assign sum_lo   = {1'b0, sum[15:0]};
  assign deriv_hi = deriv[DERIV_W-1:16];
  assign deriv_lo = {1'b0, deriv[15:0]};

  assign pp_ready = !term_valid || term_ready;
  assign in_ready = !pp_valid || pp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else if (in_ready) begin
      pp_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      pp_p_hi  <= cfg.prop_gain * err_hi;
      pp_p_lo  <= cfg.prop_gain * err_lo;
      pp_i_hi  <= cfg.integral_gain_per_tick * sum_hi;
      pp_i_lo  <= cfg.integral_gain_per_tick * sum_lo;
      pp_d_hi  <= cfg.deriv_gain_per_tick * deriv_hi;
      pp_d_lo  <= cfg.deriv_gain_per_tick * deriv_lo;
      pp_flags <= flags;
    end
  end

  // (a*b) >>> 16 == a*b_hi + ((a*b_lo) >>> 16)
  assign full_p = 66'(pp_p_hi) + 66'(pp_p_lo >>> 16);
  assign full_i = 66'(pp_i_hi) + 66'(pp_i_lo >>> 16);
  assign full_d = 66'(pp_d_hi) + 66'(pp_d_lo >>> 16);

  function automatic logic signed [TERM_W-1:0] clamp_term(input logic signed [65:0] v);
    logic signed [65:0] r;
    if (v > TERM_LIM) begin
      r = TERM_LIM;
    end else if (v < -TERM_LIM) begin
      r = -TERM_LIM;
    end else begin
      r = v;
    end
    return r[TERM_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else if (pp_ready) begin
      term_valid <= pp_valid;
    end
    if (pp_valid && pp_ready) begin
      term_p     <= clamp_term(full_p);
      term_i     <= clamp_term(full_i);
      term_d     <= clamp_term(full_d);
      term_flags <= pp_flags;
    end
  end

endmodule

### rtl/wdp_out.sv
// ----------------------------------------------------------------------------
// wdp_out
// Term sum, upper cap at the speed limit, 32-bit saturation, stop and boost overrides, result register.
// ----------------------------------------------------------------------------
module wdp_out import wdp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  wdp_cfg_t                 cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TERM_W-1:0] term_p,
  input  logic signed [TERM_W-1:0] term_i,
  input  logic signed [TERM_W-1:0] term_d,
  input  wdp_flags_t               flags,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       speed_command,
  output logic [1:0]               target_number,
  output logic                     boost_used,
  output logic                     arrived,
  output logic                     finished
);

  logic signed [64:0] total;
  logic signed [64:0] limit;
  logic signed [64:0] capped;
  logic signed [31:0] cmd;

  assign in_ready = !out_valid || !out_stall;

  assign total = 65'(term_p) + 65'(term_i) + 65'(term_d);
  assign limit = 65'(cfg.speed_limit);

  always_comb begin
    capped = (total > limit) ? limit : total;
    // cap is already within the 32-bit range from above
    if (flags.done) begin
      cmd = '0;
    end else if (flags.boost) begin
      cmd = cfg.speed_limit;
    end else if (capped < CMD_MIN) begin
      cmd = CMD_MIN[31:0];
    end else begin
      cmd = capped[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      speed_command <= cmd;
      target_number <= flags.idx;
      boost_used    <= flags.boost;
      arrived       <= flags.arrived;
      finished      <= flags.finished;
    end
  end

endmodule

### tb/wdp_checker.sv
// ----------------------------------------------------------------------------
// wdp_checker
// Watches the config, input and output channels of the waypoint distance PID
// controller. It keeps its own copy of the registers and the PID state,
// predicts the speed command for every accepted distance and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module wdp_checker import wdp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [31:0]   measured_distance,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [31:0]   speed_command,
  input  logic [1:0]           target_number,
  input  logic                 boost_used,
  input  logic                 arrived,
  input  logic                 finished,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int unsigned          fail_count,
  output int unsigned          outstanding
);

  typedef struct packed {
    logic signed [31:0] speed;
    logic [1:0]         tnum;
    logic               boost;
    logic               arrived;
    logic               finished;
  } tick_result_t;

  localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [79:0] TERM_CAP = 80'sh2000_0000_0000_0000;
  localparam logic signed [79:0] CMD_HI   = 80'sd2147483647;
  localparam logic signed [79:0] CMD_LO   = -80'sd2147483648;

  wdp_cfg_t                settings;
  logic signed [SUM_W-1:0] err_acc;
  logic signed [ERR_W-1:0] prev_err;
  logic [1:0]              wp_idx;
  tick_result_t            ticks_q[$];
  tick_result_t            want;

  // gain * operand >> 16 with floor rounding, limited to +-2^61
  function automatic logic signed [79:0] scaled_term(input logic signed [31:0] gain,
                                                     input logic signed [SUM_W-1:0] operand);
    logic signed [79:0] g;
    logic signed [79:0] o;
    logic signed [79:0] p;
    g = gain;
    o = operand;
    p = (g * o) >>> 16;
    if (p > TERM_CAP) p = TERM_CAP;
    if (p < -TERM_CAP) p = -TERM_CAP;
    return p;
  endfunction

  function automatic tick_result_t next_tick(input logic signed [31:0] distance);
    tick_result_t            r;
    logic signed [ERR_W-1:0] t_ext;
    logic signed [ERR_W-1:0] d_ext;
    logic signed [ERR_W-1:0] e;
    logic signed [SUM_W:0]   acc;
    logic signed [DERIV_W-1:0] de;
    logic signed [79:0]      total;
    logic signed [79:0]      lim;
    r = '0;
    if (wp_idx >= NUM_TARGETS_DEF) begin
      r.tnum     = IDX_DONE;
      r.finished = 1'b1;
      return r;
    end
    case (wp_idx)
      2'd0:    t_ext = settings.target_first;
      2'd1:    t_ext = settings.target_second;
      default: t_ext = settings.target_third;
    endcase
    d_ext  = distance;
    e      = t_ext - d_ext;
    r.tnum = wp_idx;
    if (wp_idx == 2'd0 && distance < settings.boost_distance) begin
      // near the start: full speed, PID state left alone
      r.boost = 1'b1;
      r.speed = settings.speed_limit;
    end else begin
      acc = err_acc + e;
      if (acc > SUM_HI) acc = SUM_HI;
      if (acc < SUM_LO) acc = SUM_LO;
      err_acc  = acc[SUM_W-1:0];
      de       = e - prev_err;
      prev_err = e;
      total = scaled_term(settings.prop_gain, e)
            + scaled_term(settings.integral_gain_per_tick, err_acc)
            + scaled_term(settings.deriv_gain_per_tick, de);
      lim = settings.speed_limit;
      if (total > lim) total = lim;
      if (total > CMD_HI) total = CMD_HI;
      if (total < CMD_LO) total = CMD_LO;
      r.speed = total[31:0];
    end
    if (e >= -ARRIVE_TOL && e <= ARRIVE_TOL) begin
      r.arrived = 1'b1;
      err_acc   = '0;
      prev_err  = '0;
      wp_idx    = wp_idx + 2'd1;
      r.finished = (wp_idx >= NUM_TARGETS_DEF);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings.prop_gain              = RST_PROP_GAIN;
      settings.integral_gain_per_tick = RST_INTEGRAL_GAIN;
      settings.deriv_gain_per_tick    = RST_DERIV_GAIN;
      settings.speed_limit            = RST_SPEED_LIMIT;
      settings.boost_distance         = RST_BOOST_DIST;
      settings.target_first           = RST_TARGET_FIRST;
      settings.target_second          = RST_TARGET_SECOND;
      settings.target_third           = RST_TARGET_THIRD;
      err_acc    = '0;
      prev_err   = '0;
      wp_idx     = '0;
      fail_count = 0;
      ticks_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:     settings.prop_gain              = cfg_data;
          REG_INTEGRAL_GAIN: settings.integral_gain_per_tick = cfg_data;
          REG_DERIV_GAIN:    settings.deriv_gain_per_tick    = cfg_data;
          REG_SPEED_LIMIT:   settings.speed_limit            = cfg_data;
          REG_BOOST_DIST:    settings.boost_distance         = cfg_data;
          REG_TARGET_FIRST:  settings.target_first           = cfg_data;
          REG_TARGET_SECOND: settings.target_second          = cfg_data;
          REG_TARGET_THIRD:  settings.target_third           = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) ticks_q.push_back(next_tick(measured_distance));
      if (out_valid && !out_stall) begin
        if (ticks_q.size() == 0) begin
          $error("unexpected result transaction: speed_command %0d", speed_command);
          fail_count++;
        end else begin
          want = ticks_q.pop_front();
          if (speed_command !== want.speed) begin
            $error("speed_command: expected %0d, got %0d", want.speed, speed_command);
            fail_count++;
          end
          if (target_number !== want.tnum) begin
            $error("target_number: expected %0d, got %0d", want.tnum, target_number);
            fail_count++;
          end
          if (boost_used !== want.boost) begin
            $error("boost_used: expected %0b, got %0b", want.boost, boost_used);
            fail_count++;
          end
          if (arrived !== want.arrived) begin
            $error("arrived: expected %0b, got %0b", want.arrived, arrived);
            fail_count++;
          end
          if (finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, finished);
            fail_count++;
          end
        end
      end
    end
    outstanding <= ticks_q.size();
  end

endmodule

### tb/tb_waypoint_distance_pid.sv
// ----------------------------------------------------------------------------
// tb_waypoint_distance_pid
// Drives the waypoint distance PID controller through its three waypoints:
// directed extremes at reset settings, random rounds under changing register
// settings, wind-up runs at maximum error that push the integral far, and
// arrivals on a boost tick and on PID ticks. Both channels idle at random;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_waypoint_distance_pid;
  import wdp_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int MAX_IDLE     = 12;
  localparam int LATENCY      = 4;
  localparam int HOLD_CYCLES  = 200;
  localparam int NUM_REGS     = 8;
  localparam int ROUND_ITEMS  = 60;
  localparam int WINDUP_ITEMS = 135;
  // ~1550 transactions at their worst-case pace, several times over
  localparam int TIMEOUT      = 2_000_000;

  localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [31:0]   measured_distance;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [31:0]   speed_command;
  logic [1:0]           target_number;
  logic                 boost_used;
  logic                 arrived;
  logic                 finished;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int unsigned          fail_count;
  int unsigned          outstanding;

  bit                   idle_on;
  bit                   hold_req;
  int                   cur_wp;
  int                   glide;
  logic [31:0]          plan [NUM_REGS];
  logic signed [31:0]   waypoint [3];
  logic signed [31:0]   boost_level;

  waypoint_distance_pid u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .measured_distance (measured_distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .speed_command     (speed_command),
    .target_number     (target_number),
    .boost_used        (boost_used),
    .arrived           (arrived),
    .finished          (finished),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  wdp_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .measured_distance (measured_distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .speed_command     (speed_command),
    .target_number     (target_number),
    .boost_used        (boost_used),
    .arrived           (arrived),
    .finished          (finished),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return DIST_MIN;
      1:       return DIST_MAX;
      2:       return 32'd0;
      3:       return $urandom_range(0, 131072);
      4:       return -int'($urandom_range(0, 131072));
      default: return $urandom();
    endcase
  endfunction

  // keep random ticks out of the arrival window
  function automatic logic signed [31:0] steer_clear(input logic signed [31:0] d,
                                                     input logic signed [31:0] tgt);
    logic signed [ERR_W-1:0] e;
    e = tgt - d;
    if (e >= -ARRIVE_TOL && e <= ARRIVE_TOL) return d ^ 32'h4000_0000;
    return d;
  endfunction

  function automatic logic signed [31:0] draw_distance(input logic signed [31:0] tgt);
    logic signed [31:0] d;
    int                 off;
    case ($urandom_range(0, 7))
      0, 1, 2: d = $urandom();
      3: begin
        off = $urandom_range(656, 8000);
        d = $urandom_range(0, 1) ? tgt + off : tgt - off;
      end
      4: d = boost_level + int'($urandom_range(0, 4)) - 2;
      5: d = pick_value();
      default: begin
        // approach the waypoint a step at a time
        if (glide < 1024) glide = $urandom_range(4096, 1 << 24);
        glide = glide - glide / 8;
        d = tgt - glide;
      end
    endcase
    return steer_clear(d, tgt);
  endfunction

  task automatic send_distance(input logic signed [31:0] d);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    measured_distance <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and let every pending result come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), plan[i]);
    // an index past the register file must be ignored
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)), $urandom());
    cfg_valid <= 1'b0;
    waypoint[0] = plan[REG_TARGET_FIRST];
    waypoint[1] = plan[REG_TARGET_SECOND];
    waypoint[2] = plan[REG_TARGET_THIRD];
    boost_level = plan[REG_BOOST_DIST];
  endtask

  task automatic shuffle_plan();
    for (int i = 0; i < NUM_REGS; i++) plan[i] = pick_value();
  endtask

  task automatic random_round(input bit with_hold);
    logic signed [31:0] tgt;
    settle();
    shuffle_plan();
    load_settings();
    idle_on  = ($urandom_range(0, 3) != 0);
    hold_req = with_hold;
    for (int n = 0; n < ROUND_ITEMS; n++) begin
      if (cur_wp < NUM_TARGETS_DEF) tgt = waypoint[cur_wp];
      else tgt = $urandom();
      send_distance(draw_distance(tgt));
    end
  endtask

  // back-to-back run at maximum error to drive the integral far from zero
  task automatic windup(input logic signed [31:0] tgt, input bit upward);
    settle();
    shuffle_plan();
    plan[REG_BOOST_DIST] = DIST_MIN;
    plan[int'(REG_TARGET_FIRST) + cur_wp] = tgt;
    load_settings();
    idle_on = 1'b0;
    for (int n = 0; n < WINDUP_ITEMS; n++) begin
      if (upward) send_distance(DIST_MIN + int'($urandom_range(0, 255)));
      else send_distance(DIST_MAX - int'($urandom_range(0, 255)));
    end
  endtask

  task automatic reach_waypoint(input int off, input bit on_boost);
    int t;
    settle();
    shuffle_plan();
    t = int'($urandom_range(0, 32'h7FFF_FFFF)) - (1 << 30);
    plan[int'(REG_TARGET_FIRST) + cur_wp] = t;
    plan[REG_BOOST_DIST] = on_boost ? DIST_MAX : DIST_MIN;
    load_settings();
    idle_on = 1'b1;
    send_distance(t - off);
    cur_wp++;
  endtask

  initial begin : result_side
    int pause;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pause = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (pause > 0) begin
          out_stall <= 1'b1;
          repeat (pause) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    rst               <= 1'b1;
    in_valid          <= 1'b0;
    measured_distance <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    cur_wp      = 0;
    glide       = 0;
    waypoint[0] = RST_TARGET_FIRST;
    waypoint[1] = RST_TARGET_SECOND;
    waypoint[2] = RST_TARGET_THIRD;
    boost_level = RST_BOOST_DIST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: boost region, its edge, extremes, just outside arrival
    send_distance(DIST_MIN);
    send_distance(32'sd0);
    send_distance(RST_BOOST_DIST - 1);
    send_distance(RST_BOOST_DIST);
    send_distance(DIST_MAX);
    send_distance(RST_TARGET_FIRST + 656);
    send_distance(RST_TARGET_FIRST - 656);
    send_distance(RST_TARGET_FIRST - 32'sd700);

    // extreme gains, output saturating at both ends
    settle();
    plan[REG_PROP_GAIN]     = DIST_MAX;
    plan[REG_INTEGRAL_GAIN] = DIST_MIN;
    plan[REG_DERIV_GAIN]    = DIST_MAX;
    plan[REG_SPEED_LIMIT]   = DIST_MAX;
    plan[REG_BOOST_DIST]    = DIST_MIN;
    plan[REG_TARGET_FIRST]  = DIST_MAX;
    plan[REG_TARGET_SECOND] = DIST_MIN;
    plan[REG_TARGET_THIRD]  = 32'd0;
    load_settings();
    send_distance(DIST_MIN);
    send_distance(steer_clear(DIST_MAX, DIST_MAX));
    send_distance(32'sd0);
    send_distance(DIST_MIN);

    // most negative limit caps every command
    settle();
    plan[REG_PROP_GAIN]     = DIST_MIN;
    plan[REG_INTEGRAL_GAIN] = DIST_MAX;
    plan[REG_DERIV_GAIN]    = DIST_MIN;
    plan[REG_SPEED_LIMIT]   = DIST_MIN;
    plan[REG_TARGET_FIRST]  = 32'd0;
    load_settings();
    send_distance(DIST_MAX);
    send_distance(DIST_MIN);
    send_distance(steer_clear($urandom(), 32'sd0));

    // first waypoint
    random_round(1'b1);
    repeat (3) random_round(1'b0);
    windup(DIST_MAX, 1'b1);
    repeat (4) random_round(1'b0);
    reach_waypoint($urandom_range(0, 1310) - 655, 1'b1);

    // second waypoint
    repeat (3) random_round(1'b0);
    windup(DIST_MIN, 1'b0);
    repeat (3) random_round(1'b0);
    reach_waypoint(655, 1'b0);

    // third waypoint
    repeat (6) random_round(1'b0);
    reach_waypoint(-655, 1'b0);

    // all waypoints done
    random_round(1'b0);
    settle();

    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
